### rtl/ccrp_pkg.sv
// Shared types and constants for the cheat code read patcher.
`default_nettype none

package ccrp_pkg;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotIdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam logic [15:0] GenieMinAddr = 16'h8000;

  typedef enum logic [1:0] {
    OpRead       = 2'd0,
    OpLoad       = 2'd1,
    OpEnable     = 2'd2,
    OpDisableAll = 2'd3
  } ccrp_op_e;

  typedef enum logic [1:0] {
    KindSix   = 2'd0,
    KindEight = 2'd1,
    KindRaw   = 2'd2
  } ccrp_kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StReadDone,
    StExec
  } ccrp_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  slot;
    logic [1:0]  code_kind;
    logic [31:0] letter_indices;
    logic [15:0] address;
    logic [7:0]  data;
    logic        enable;
  } ccrp_in_t;

  typedef struct packed {
    logic [7:0]  genie_data;
    logic [7:0]  raw_data;
    logic [15:0] code_address;
    logic [7:0]  code_value;
    logic [7:0]  code_compare;
    logic        code_has_compare;
  } ccrp_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;      // capture accepted word, restart walk
    logic step;       // apply one slot of the walk
    logic load_read;  // move walk results to the output register
    logic exec;       // perform load / enable / disable and load output
  } ccrp_cmd_t;

  typedef struct packed {
    logic walk_last;
  } ccrp_status_t;

endpackage

`default_nettype wire

### rtl/ccrp_ctrl.sv
// Controller state machine for the cheat code read patcher.
`default_nettype none

module ccrp_ctrl
  import ccrp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic [1:0]   in_opcode_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire ccrp_status_t status_i,
  output ccrp_cmd_t         cmd_o
);

  ccrp_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = (in_opcode_i == OpRead) ? StWalk : StExec;
        end
      end
      StWalk: begin
        cmd_o.step = 1'b1;
        if (status_i.walk_last) begin
          state_d = StReadDone;
        end
      end
      StReadDone: begin
        if (out_free) begin
          cmd_o.load_read = 1'b1;
          state_d = StIdle;
        end
      end
      StExec: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_read || cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/ccrp_datapath.sv
// Slot table, letter decoder, slot walk and output register.
`default_nettype none

module ccrp_datapath
  import ccrp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ccrp_in_t  in_word_i,
  input  wire ccrp_cmd_t cmd_i,
  output ccrp_status_t   status_o,
  output ccrp_out_t      out_word_o
);

  typedef struct packed {
    logic        raw;
    logic        has_cmp;
    logic [15:0] addr;
    logic [7:0]  val;
    logic [7:0]  cmp;
  } entry_t;

  entry_t                entry_q [NumSlots];
  logic [NumSlots-1:0]   valid_q, valid_d;
  logic [NumSlots-1:0]   en_q, en_d;

  ccrp_in_t              item_q;
  logic [SlotIdxW-1:0]   cnt_q;
  logic [7:0]            g_q, g_d;
  logic [7:0]            r_q, r_d;
  ccrp_out_t             out_q;

  entry_t                cur;
  entry_t                new_entry;
  logic                  hit;
  logic                  slot_ok;
  logic [SlotIdxW-1:0]   slot_idx;
  logic                  load_ok;
  ccrp_out_t             exec_out;

  // Letter code to address / value / compare
  function automatic entry_t decode(input logic [31:0] l, input logic eight);
    logic [3:0] n0, n1, n2, n3, n4, n5, n6, n7;
    entry_t e;
    n0 = l[3:0];   n1 = l[7:4];   n2 = l[11:8];  n3 = l[15:12];
    n4 = l[19:16]; n5 = l[23:20]; n6 = l[27:24]; n7 = l[31:28];
    e = '0;
    e.addr = {1'b1, n3[2:0], n4[3], n5[2:0], n1[3], n2[2:0], n3[3], n4[2:0]};
    if (eight) begin
      e.val     = {n0[3], n1[2:0], n7[3], n0[2:0]};
      e.cmp     = {n6[3], n7[2:0], n5[3], n6[2:0]};
      e.has_cmp = 1'b1;
    end else begin
      e.val = {n0[3], n1[2:0], n5[3], n0[2:0]};
    end
    return e;
  endfunction

  assign slot_idx = SlotIdxW'(item_q.slot);
  assign slot_ok  = ({28'd0, item_q.slot} < 32'(NumSlots));
  assign status_o.walk_last = (cnt_q == SlotIdxW'(NumSlots - 1));

  // One slot per walk step
  assign cur = entry_q[cnt_q];
  assign hit = valid_q[cnt_q] && en_q[cnt_q] && (cur.addr == item_q.address);

  always_comb begin
    g_d = g_q;
    r_d = r_q;
    if (hit) begin
      if (cur.raw) begin
        r_d = cur.val;
      end else if (item_q.address >= GenieMinAddr) begin
        if (!cur.has_cmp || (cur.cmp == g_q)) begin
          g_d = cur.val;
        end
      end
    end
  end

  always_comb begin
    new_entry = '0;
    load_ok   = 1'b0;
    unique case (item_q.code_kind)
      KindSix: begin
        new_entry = decode(item_q.letter_indices, 1'b0);
        load_ok   = slot_ok;
      end
      KindEight: begin
        new_entry = decode(item_q.letter_indices, 1'b1);
        load_ok   = slot_ok;
      end
      KindRaw: begin
        new_entry.raw  = 1'b1;
        new_entry.addr = item_q.address;
        new_entry.val  = item_q.data;
        load_ok        = slot_ok;
      end
      default: load_ok = 1'b0;
    endcase
  end

  always_comb begin
    exec_out = '0;
    valid_d  = valid_q;
    en_d     = en_q;
    if (cmd_i.exec) begin
      unique case (item_q.opcode)
        OpLoad: begin
          if (load_ok) begin
            valid_d[slot_idx]         = 1'b1;
            en_d[slot_idx]            = item_q.enable;
            exec_out.code_address     = new_entry.addr;
            exec_out.code_value       = new_entry.val;
            exec_out.code_compare     = new_entry.cmp;
            exec_out.code_has_compare = new_entry.has_cmp;
          end
        end
        OpEnable: begin
          if (slot_ok && valid_q[slot_idx]) begin
            en_d[slot_idx] = item_q.enable;
          end
        end
        OpDisableAll: en_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      en_q    <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      en_q    <= en_d;
      if (cmd_i.latch) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + SlotIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (item_q.opcode == OpLoad) && load_ok) begin
      entry_q[slot_idx] <= new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_word_i;
      g_q    <= in_word_i.data;
      r_q    <= in_word_i.data;
    end else if (cmd_i.step) begin
      g_q <= g_d;
      r_q <= r_d;
    end
    if (cmd_i.load_read) begin
      out_q <= '{genie_data: g_q, raw_data: r_q, default: '0};
    end else if (cmd_i.exec) begin
      out_q <= exec_out;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

### rtl/cheat_code_read_patcher.sv
// Top level of the cheat code read patcher.
`default_nettype none

// Cheat code read patcher. Sixteen cheat slots patch CPU read data. Each input
// word carries one command: a bus read, a slot load (six- or eight-letter code
// given as 4-bit alphabet indices, or a raw address/value pair), a slot enable
// update, or disable-all. Every accepted word produces exactly one output
// word. A bus read walks the slots in ascending order, one slot per clock,
// and returns two patched bytes: genie_data (letter codes, only for
// addresses 0x8000 and up, last match wins, compare bytes checked against the
// running value) and raw_data (raw slots, any address, last match wins).
// Sequence: a bus read walks every slot of the table in turn, then loads
// its result into the output register; load, enable and disable words
// go straight to the output load after accept. Either output load waits
// while a stalled output still holds an unaccepted result. One word is in
// flight at a time; the output register lets the next word be accepted while
// a finished result waits.
// All slots come out of reset invalid and disabled.

module cheat_code_read_patcher
  import ccrp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ccrp_in_t in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output ccrp_out_t     out_word_o
);

  ccrp_cmd_t    cmd;
  ccrp_status_t status;

  ccrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_word_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ccrp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire
